// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// Each property is clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition on every cycle.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence starting in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/dfd_pkg.sv -----
`default_nettype none

package dfd_pkg;

    // Request operation codes
    localparam logic [1:0] OP_ABSORB_BYTE = 2'd0;
    localparam logic [1:0] OP_ABSORB_PART = 2'd1;
    localparam logic [1:0] OP_FINISH      = 2'd2;

    // Lane A: standard 64-bit offset, prime 2^40 + 0x1b3
    localparam logic [63:0] LANE_A_OFFSET    = 64'hcbf2_9ce4_8422_2325;
    localparam int          LANE_A_SHIFT     = 40;
    localparam logic [8:0]  LANE_A_PRIME_LOW = 9'h1b3;

    // Lane B: golden-ratio offset, mixed full-width prime
    localparam logic [63:0] LANE_B_OFFSET = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] LANE_B_PRIME  = 64'h0000_0100_0000_01b3 ^ 64'hff51_afd7_ed55_8ccd;

    // Part digest text: 32 hex characters then the separator
    localparam int         PART_BITS      = 128;
    localparam int         HEX_DIGITS     = PART_BITS / 4;
    localparam int         HEX_CNT_W      = $clog2(HEX_DIGITS + 1);
    localparam logic [7:0] PART_SEPARATOR = 8'h1f;

    // Command queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  byte_value;
        logic [63:0] part_high;
        logic [63:0] part_low;
    } t_in_req;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_out_res;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_PART,
        CMD_FINISH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  byte_value;
        logic [63:0] part_high;
        logic [63:0] part_low;
    } t_cmd;

    // One byte step toward the lanes, or a finish marker
    typedef struct packed {
        logic       finish;
        logic [7:0] byte_value;
    } t_step;

endpackage

`default_nettype wire

// ----- design/dfd_front.sv -----
`default_nettype none

module dfd_front
    import dfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_in_req i_req,
    output logic         o_cmd_valid,
    input  wire logic    i_cmd_ready,
    output t_cmd         o_cmd
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    t_cmd w_cmd;
    logic w_keep;
    logic w_push;
    logic w_pop;

    // Classify the request; drop unused operation codes
    always_comb begin
        w_cmd.byte_value = i_req.byte_value;
        w_cmd.part_high  = i_req.part_high;
        w_cmd.part_low   = i_req.part_low;
        w_cmd.kind       = CMD_BYTE;
        w_keep           = 1'b1;
        case (i_req.operation)
            OP_ABSORB_BYTE: w_cmd.kind = CMD_BYTE;
            OP_ABSORB_PART: w_cmd.kind = CMD_PART;
            OP_FINISH:      w_cmd.kind = CMD_FINISH;
            default:        w_keep     = 1'b0;
        endcase
    end

    assign o_req_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    assign w_push = i_req_valid && o_req_ready && w_keep;
    assign w_pop  = o_cmd_valid && i_cmd_ready;

    // Store classified commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/dfd_expand.sv -----
`default_nettype none
`include "assert_macros.svh"

module dfd_expand
    import dfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    output logic      o_step_valid,
    input  wire logic i_step_ready,
    output t_step     o_step
);

    typedef enum logic {
        S_PASS,
        S_HEX
    } t_state;

    t_state                 r_state;
    logic [PART_BITS-1:0]   r_digits;
    logic [HEX_CNT_W-1:0]   r_cnt;

    // Lowercase ASCII for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'b0, nib};
        end
        return 8'h57 + {4'b0, nib};
    endfunction

    // Pass single bytes and finish through; serialize part digests
    always_comb begin
        o_step_valid      = 1'b0;
        o_cmd_ready       = 1'b0;
        o_step.finish     = 1'b0;
        o_step.byte_value = i_cmd.byte_value;
        case (r_state)
            S_PASS: begin
                o_step_valid  = i_cmd_valid && (i_cmd.kind != CMD_PART);
                o_step.finish = (i_cmd.kind == CMD_FINISH);
                o_cmd_ready   = (i_cmd.kind == CMD_PART) || i_step_ready;
            end
            S_HEX: begin
                o_step_valid = 1'b1;
                if (r_cnt == HEX_CNT_W'(HEX_DIGITS)) begin
                    o_step.byte_value = PART_SEPARATOR;
                end else begin
                    o_step.byte_value = hex_char(r_digits[PART_BITS-1 -: 4]);
                end
            end
            default: begin
                o_step_valid = 1'b0;
            end
        endcase
    end

    // Hold the digest text and walk it one character per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PASS;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_PASS: begin
                    if (i_cmd_valid && (i_cmd.kind == CMD_PART)) begin
                        r_digits <= {i_cmd.part_high, i_cmd.part_low};
                        r_cnt    <= '0;
                        r_state  <= S_HEX;
                    end
                end
                S_HEX: begin
                    if (i_step_ready) begin
                        if (r_cnt == HEX_CNT_W'(HEX_DIGITS)) begin
                            r_state <= S_PASS;
                        end else begin
                            r_digits <= r_digits << 4;
                            r_cnt    <= r_cnt + 1'b1;
                        end
                    end
                end
                default: r_state <= S_PASS;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= HEX_CNT_W'(HEX_DIGITS), "hex count overrun")
    `ASSERT_NEXT(a_part_load, i_clk, i_rst_n, (r_state == S_PASS) && i_cmd_valid && (i_cmd.kind == CMD_PART), (r_state == S_HEX) && (r_cnt == '0), "part digest not loaded")
    `ASSERT_NEXT(a_sep_done, i_clk, i_rst_n, (r_state == S_HEX) && (r_cnt == HEX_CNT_W'(HEX_DIGITS)) && i_step_ready, r_state == S_PASS, "no return after separator")

endmodule

`default_nettype wire

// ----- design/dfd_lanes.sv -----
`default_nettype none
`include "assert_macros.svh"

module dfd_lanes
    import dfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step_valid,
    output logic      o_step_ready,
    input  wire t_step i_step,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_out_res  o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CROSS_HI,
        S_CROSS_LO
    } t_state;

    t_state      r_state;
    logic [63:0] r_hash_a;
    logic [63:0] r_hash_b;
    logic [63:0] r_t;
    logic [63:0] r_acc;
    logic        r_res_valid;
    t_out_res    r_res;

    logic [63:0] w_ta;
    logic [63:0] w_tb;
    logic [63:0] w_next_a;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic        w_fire;

    // XOR the byte into both lanes
    assign w_ta = r_hash_a ^ {56'b0, i_step.byte_value};
    assign w_tb = r_hash_b ^ {56'b0, i_step.byte_value};

    // Lane A prime is a shift plus a small constant
    assign w_next_a = (w_ta << LANE_A_SHIFT) + (w_ta * 64'(LANE_A_PRIME_LOW));

    // Share one 32x32 multiplier over the three partial products of lane B
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_mul_a = w_tb[31:0];
                w_mul_b = LANE_B_PRIME[31:0];
            end
            S_CROSS_HI: begin
                w_mul_a = r_t[63:32];
                w_mul_b = LANE_B_PRIME[31:0];
            end
            S_CROSS_LO: begin
                w_mul_a = r_t[31:0];
                w_mul_b = LANE_B_PRIME[63:32];
            end
            default: begin
                w_mul_a = w_tb[31:0];
                w_mul_b = LANE_B_PRIME[31:0];
            end
        endcase
    end

    assign w_prod = {32'b0, w_mul_a} * {32'b0, w_mul_b};

    // Take a step when idle; a finish also needs room in the result register
    assign o_step_ready = (r_state == S_IDLE)
                          && (!i_step.finish || !r_res_valid || i_res_ready);
    assign w_fire       = i_step_valid && o_step_ready;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Advance the lanes and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash_a    <= LANE_A_OFFSET;
            r_hash_b    <= LANE_B_OFFSET;
            r_res_valid <= 1'b0;
        end else begin
            // Drop a taken result unless a new one replaces it
            if (r_res_valid && i_res_ready && !(w_fire && i_step.finish)) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_fire) begin
                        if (i_step.finish) begin
                            r_res.digest_high <= r_hash_b;
                            r_res.digest_low  <= r_hash_a;
                            r_res_valid       <= 1'b1;
                            r_hash_a          <= LANE_A_OFFSET;
                            r_hash_b          <= LANE_B_OFFSET;
                        end else begin
                            r_t      <= w_tb;
                            r_acc    <= w_prod;
                            r_hash_a <= w_next_a;
                            r_state  <= S_CROSS_HI;
                        end
                    end
                end
                S_CROSS_HI: begin
                    r_acc   <= r_acc + {w_prod[31:0], 32'b0};
                    r_state <= S_CROSS_LO;
                end
                S_CROSS_LO: begin
                    r_hash_b <= r_acc + {w_prod[31:0], 32'b0};
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_finish_reload, i_clk, i_rst_n, w_fire && i_step.finish, r_res_valid && (r_hash_a == LANE_A_OFFSET) && (r_hash_b == LANE_B_OFFSET), "lanes not reloaded on finish")
    `ASSERT_NEXT(a_byte_phases, i_clk, i_rst_n, w_fire && !i_step.finish, ((r_state == S_CROSS_HI) && $stable(r_hash_b)) ##1 ((r_state == S_CROSS_LO) && $stable(r_hash_b)) ##1 (r_state == S_IDLE), "lane B sequence broken")
    `ASSERT_NEXT(a_lane_a_hold, i_clk, i_rst_n, !w_fire, $stable(r_hash_a), "lane A moved without a step")

endmodule

`default_nettype wire

// ----- design/dual_fnv1a_digest.sv -----
// A finish request passes the command queue, then the result register, to reach o_res_valid.
// A byte request walks the hash lanes through S_IDLE, S_CROSS_HI and S_CROSS_LO (one shared
// 32x32 multiplier), taking no new step before S_IDLE; a part digest becomes 33 characters.
// A 2-entry command queue lets requests be accepted while the lanes are busy.
// Reset: synchronous, active low; lanes reload their offsets, queue and result empty.
`default_nettype none

module dual_fnv1a_digest
    import dfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_in_req i_req,
    output logic         o_res_valid,
    input  wire logic    i_res_ready,
    output t_out_res     o_res
);

    logic  w_cmd_valid;
    logic  w_cmd_ready;
    t_cmd  w_cmd;
    logic  w_step_valid;
    logic  w_step_ready;
    t_step w_step;

    // Accept and queue requests
    dfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Turn commands into byte steps
    dfd_expand u_expand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd        (w_cmd),
        .o_step_valid (w_step_valid),
        .i_step_ready (w_step_ready),
        .o_step       (w_step)
    );

    // Run both hash lanes and emit digests
    dfd_lanes u_lanes (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (w_step_valid),
        .o_step_ready (w_step_ready),
        .i_step       (w_step),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

// ----- sim/dfd_digest_checker.sv -----
`default_nettype none

module dfd_digest_checker
    import dfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    input  wire logic     i_req_ready,
    input  wire t_in_req  i_req,
    input  wire logic     i_res_valid,
    input  wire logic     i_res_ready,
    input  wire t_out_res i_res,
    output int            o_mismatch_count,
    output int            o_digests_owed
);

    // Lane parameters, kept apart from the design's own copies
    localparam logic [63:0] STD_OFFSET    = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] STD_PRIME     = 64'h0000_0100_0000_01b3;
    localparam logic [63:0] GOLD_OFFSET   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] GOLD_PRIME    = 64'h0000_0100_0000_01b3 ^ 64'hff51_afd7_ed55_8ccd;
    localparam logic [7:0]  HEX_SEPARATOR = 8'h1f;

    logic [63:0] std_lane;
    logic [63:0] gold_lane;
    t_out_res    digest_queue[$];

    // Mix one character into both lanes
    function automatic void fold_char(input logic [7:0] ch);
        std_lane  = (std_lane ^ {56'd0, ch}) * STD_PRIME;
        gold_lane = (gold_lane ^ {56'd0, ch}) * GOLD_PRIME;
    endfunction

    // Lowercase hex digit; 8'h57 is 'a' minus ten
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    // Mix a word as 16 hex characters, most significant nibble first
    function automatic void fold_word_hex(input logic [63:0] word);
        for (int i = 15; i >= 0; i--) begin
            fold_char(hex_char(word[i*4 +: 4]));
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_out_res want;
        t_out_res made;
        if (!i_rst_n) begin
            std_lane = STD_OFFSET;
            gold_lane = GOLD_OFFSET;
            digest_queue.delete();
            o_mismatch_count = 0;
            o_digests_owed = 0;
        end else begin
            // Compare a delivered digest with the oldest one owed
            if (i_res_valid && i_res_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest %h_%h", i_res.digest_high, i_res.digest_low);
                    o_mismatch_count++;
                end else begin
                    want = digest_queue.pop_front();
                    if (i_res.digest_high !== want.digest_high) begin
                        $error("digest_high: expected %h, actual %h",
                               want.digest_high, i_res.digest_high);
                        o_mismatch_count++;
                    end
                    if (i_res.digest_low !== want.digest_low) begin
                        $error("digest_low: expected %h, actual %h",
                               want.digest_low, i_res.digest_low);
                        o_mismatch_count++;
                    end
                end
            end

            // Advance the lanes on an accepted request
            if (i_req_valid && i_req_ready) begin
                case (i_req.operation)
                    OP_ABSORB_BYTE: begin
                        fold_char(i_req.byte_value);
                    end
                    OP_ABSORB_PART: begin
                        fold_word_hex(i_req.part_high);
                        fold_word_hex(i_req.part_low);
                        fold_char(HEX_SEPARATOR);
                    end
                    OP_FINISH: begin
                        made.digest_high = gold_lane;
                        made.digest_low = std_lane;
                        digest_queue = {digest_queue, made};
                        std_lane = STD_OFFSET;
                        gold_lane = GOLD_OFFSET;
                    end
                    default: begin
                        // unused code: drop it, lanes hold
                    end
                endcase
            end
            o_digests_owed = digest_queue.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_dual_fnv1a_digest.sv -----
`default_nettype none

module tb_dual_fnv1a_digest;
    import dfd_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASE_ITEMS = 200;
    localparam int         SEND_IDLE[4]  = '{0, 49, 0, 7};
    localparam int         RECV_STALL[4] = '{0, 0, 49, 7};

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    t_in_req  req = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    t_out_res res;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hashed_items = 0;
    int mismatch_count;
    int digests_owed;

    dual_fnv1a_digest dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    dfd_digest_checker scoreboard (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_ready      (req_ready),
        .i_req            (req),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_res            (res),
        .o_mismatch_count (mismatch_count),
        .o_digests_owed   (digests_owed)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stall the digest side at the current rate
    always @(negedge clk) begin
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic t_in_req make_req(input logic [1:0] op, input logic [7:0] data,
                                         input logic [63:0] hi, input logic [63:0] lo);
        t_in_req r;
        r.operation = op;
        r.byte_value = data;
        r.part_high = hi;
        r.part_low = lo;
        return r;
    endfunction

    // Randomize every field, used or not
    function automatic t_in_req rand_req(input logic [1:0] op);
        return make_req(op, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    // Hold a request until accepted; call and return just after a falling edge
    task automatic push_request(input t_in_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        if (r.operation != OP_UNUSED) hashed_items++;
        @(negedge clk);
    endtask

    // One message: some bytes, parts and stray codes, then a finish
    task automatic send_random_message();
        int len;
        int pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) push_request(rand_req(OP_ABSORB_BYTE));
            else if (pick < 90) push_request(rand_req(OP_ABSORB_PART));
            else push_request(rand_req(OP_UNUSED));
        end
        push_request(rand_req(OP_FINISH));
    endtask

    initial begin : stimulus
        int target;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty messages, byte extremes, part extremes, stray codes
        push_request(make_req(OP_FINISH, 8'h00, '0, '0));
        push_request(make_req(OP_FINISH, 8'hff, '1, '1));
        push_request(make_req(OP_ABSORB_BYTE, 8'h00, '1, '1));
        push_request(make_req(OP_ABSORB_BYTE, 8'hff, '0, '0));
        push_request(make_req(OP_FINISH, 8'h00, '0, '0));
        push_request(make_req(OP_ABSORB_PART, 8'hff, '0, '0));
        push_request(make_req(OP_FINISH, 8'h00, '0, '0));
        push_request(make_req(OP_ABSORB_PART, 8'h00, '1, '1));
        push_request(make_req(OP_ABSORB_PART, 8'h5a, 64'h0123_4567_89ab_cdef,
                              64'hfedc_ba98_7654_3210));
        push_request(make_req(OP_UNUSED, 8'hff, '1, '1));
        push_request(make_req(OP_ABSORB_BYTE, 8'h5a, '0, '0));
        push_request(make_req(OP_FINISH, 8'h00, '0, '0));
        push_request(make_req(OP_UNUSED, 8'h00, '0, '0));
        push_request(make_req(OP_FINISH, 8'h00, '0, '0));
        push_request(make_req(OP_ABSORB_PART, 8'h00, '1, '0));
        push_request(make_req(OP_ABSORB_BYTE, 8'ha5, '0, '1));
        push_request(make_req(OP_ABSORB_BYTE, 8'h80, '0, '0));
        push_request(make_req(OP_FINISH, 8'h00, '0, '0));

        // Random messages under each idling pattern
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            target = hashed_items + PHASE_ITEMS;
            while (hashed_items < target) send_random_message();
        end
        req_valid <= 1'b0;

        // Drain owed digests, then watch for strays
        while (digests_owed != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/dfd_pkg.sv
design/dfd_front.sv
design/dfd_expand.sv
design/dfd_lanes.sv
design/dual_fnv1a_digest.sv
sim/dfd_digest_checker.sv
sim/tb_dual_fnv1a_digest.sv
